/* hw/rtl/scheduled_key_event_wheel_assert.svh */
// assertion macros shared by the wheel scheduler
`ifndef SCHEDULED_KEY_EVENT_WHEEL_ASSERT_SVH
`define SCHEDULED_KEY_EVENT_WHEEL_ASSERT_SVH

// same-cycle implication
`define SKEW_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication
`define SKEW_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

/* hw/rtl/skew_pkg.sv */
`timescale 1ns / 1ps

package skew_pkg;

   localparam int TIME_W = 32;
   localparam int TIMEOUT_W = 16;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;

   // command codes of a request
   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_DOWN  = 3'd1,
      CMD_UP    = 3'd2,
      CMD_PING  = 3'd3,
      CMD_CHECK = 3'd4,
      CMD_CLEAR = 3'd5
   } cmd_type;

   // acknowledge codes
   typedef enum logic [2:0] {
      ACK_NONE    = 3'd0,
      ACK_PING    = 3'd1,
      ACK_DOWN    = 3'd2,
      ACK_UP      = 3'd3,
      ACK_CHECK   = 3'd4,
      ACK_CLEARED = 3'd5
   } ack_type;

   // slot contents
   typedef enum logic [1:0] {
      MARK_NONE = 2'd0,
      MARK_DOWN = 2'd1,
      MARK_UP   = 2'd2
   } mark_type;

   // register indexes
   typedef enum logic [1:0] {
      REG_INVERT  = 2'd0,
      REG_ENABLE  = 2'd1,
      REG_LINE    = 2'd2,
      REG_TIMEOUT = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_TICK,
      ST_MOD,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic                 invert_level;
      logic                 output_enable;
      logic                 line_select;
      logic [TIMEOUT_W-1:0] down_timeout_ms;
   } cfg_type;

endpackage

/* hw/rtl/scheduled_key_event_wheel.sv */
`timescale 1ns / 1ps
// ping, check and unknown commands: result registered in the cycle after the request, busy stays low.
// tick: one wheel read, then the result is registered in the tick state with the write-back.
// schedule down/up: result registered when the staged slot remainder is done.
// clear: one slot written per cycle across the whole wheel. results cannot be stalled.
// after reset busy is high while the wheel is swept empty.

`include "scheduled_key_event_wheel_assert.svh"

module scheduled_key_event_wheel #(
   parameter int WHEEL_SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_target_time,
   input  logic [31:0] req_origin_time,
   output logic        rsp_valid,
   output logic [2:0]  rsp_ack_code,
   output logic [31:0] rsp_origin_echo,
   output logic [31:0] rsp_target_echo,
   output logic [31:0] rsp_sent_time,
   output logic        rsp_dtr_level,
   output logic        rsp_rts_level,
   output logic        rsp_key_is_down,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int SLOT_W = $clog2(WHEEL_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WHEEL_SLOTS - 1);

   skew_pkg::cfg_type   cfg;
   skew_pkg::state_type state_ff, state_in;
   skew_pkg::cmd_type   req_cmd;

   logic accept;

   // wheel port
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   logic [1:0]        mem_wr_data;
   logic              mem_rd_en;
   logic [SLOT_W-1:0] mem_rd_addr;
   logic [1:0]        mem_rd_data;

   logic              mod_start;
   logic              mod_done;
   logic [SLOT_W-1:0] mod_slot;

   // control state
   logic [31:0]       now_ms_ff, now_ms_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [SLOT_W-1:0] next_slot;
   logic [SLOT_W-1:0] walk_ff, walk_in;
   logic [31:0]       down_start_ff, down_start_in;
   logic              armed_ff, armed_in;
   logic              key_ff, key_in;
   logic              dtr_ff, dtr_in;
   logic              rts_ff, rts_in;

   // held request
   logic              hold_down_ff, hold_down_in;
   logic [31:0]       hold_target_ff, hold_target_in;
   logic [31:0]       hold_origin_ff, hold_origin_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_ack_ff, rsp_ack_in;
   logic [31:0]       rsp_origin_ff, rsp_origin_in;
   logic [31:0]       rsp_target_ff, rsp_target_in;
   logic [31:0]       rsp_sent_ff, rsp_sent_in;
   logic              rsp_dtr_ff, rsp_dtr_in;
   logic              rsp_rts_ff, rsp_rts_in;
   logic              rsp_key_ff, rsp_key_in;

   // tick evaluation
   logic              wd_fire;
   logic              mark_dn;
   logic              mark_up;
   logic              key_event;
   logic              event_level;
   logic              dtr_tick;
   logic              rts_tick;
   logic              dtr_clr;
   logic              rts_clr;

   assign req_cmd   = skew_pkg::cmd_type'(req_command);
   assign accept    = start && (state_ff == skew_pkg::ST_IDLE);
   assign next_slot = (cur_slot_ff == LAST_SLOT) ? '0 : (cur_slot_ff + SLOT_W'(1));

   skew_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   skew_wheel_ram #(
      .DEPTH  (WHEEL_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   skew_slot_mod #(
      .SLOTS  (WHEEL_SLOTS),
      .SLOT_W (SLOT_W)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_target_time),
      .done     (mod_done),
      .slot     (mod_slot)
   );

   // watchdog and fired mark, in model order
   always_comb begin
      wd_fire = armed_ff &&
                ((now_ms_ff - down_start_ff) > {16'b0, cfg.down_timeout_ms});
      mark_dn     = (mem_rd_data == skew_pkg::MARK_DOWN);
      mark_up     = (mem_rd_data == skew_pkg::MARK_UP);
      key_event   = wd_fire || mark_dn || mark_up;
      event_level = mark_dn ? cfg.invert_level : !cfg.invert_level;
      dtr_tick    = dtr_ff;
      rts_tick    = rts_ff;
      if (key_event && cfg.output_enable) begin
         if (cfg.line_select) begin
            rts_tick = event_level;
         end else begin
            dtr_tick = event_level;
         end
      end
      // key up at the end of a clear
      dtr_clr = dtr_ff;
      rts_clr = rts_ff;
      if (cfg.output_enable) begin
         if (cfg.line_select) begin
            rts_clr = !cfg.invert_level;
         end else begin
            dtr_clr = !cfg.invert_level;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skew_pkg::ST_INIT: begin
            if (walk_ff == LAST_SLOT) state_in = skew_pkg::ST_IDLE;
         end
         skew_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  skew_pkg::CMD_TICK:  state_in = skew_pkg::ST_TICK;
                  skew_pkg::CMD_DOWN:  state_in = skew_pkg::ST_MOD;
                  skew_pkg::CMD_UP:    state_in = skew_pkg::ST_MOD;
                  skew_pkg::CMD_CLEAR: state_in = skew_pkg::ST_CLEAR;
                  default:             state_in = skew_pkg::ST_IDLE;
               endcase
            end
         end
         skew_pkg::ST_TICK: state_in = skew_pkg::ST_IDLE;
         skew_pkg::ST_MOD: begin
            if (mod_done) state_in = skew_pkg::ST_IDLE;
         end
         skew_pkg::ST_CLEAR: begin
            if (walk_ff == LAST_SLOT) state_in = skew_pkg::ST_IDLE;
         end
         default: state_in = skew_pkg::ST_INIT;
      endcase
   end

   // wheel and divider controls
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = walk_ff;
      mem_wr_data = skew_pkg::MARK_NONE;
      mem_rd_en   = 1'b0;
      mem_rd_addr = next_slot;
      mod_start   = 1'b0;
      busy        = 1'b1;
      case (state_ff)
         skew_pkg::ST_INIT: begin
            mem_wr_en = 1'b1;
         end
         skew_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (accept && (req_cmd == skew_pkg::CMD_TICK)) begin
               mem_rd_en = 1'b1;
            end
            if (accept && ((req_cmd == skew_pkg::CMD_DOWN) ||
                           (req_cmd == skew_pkg::CMD_UP))) begin
               mod_start = 1'b1;
            end
         end
         skew_pkg::ST_TICK: begin
            // fired mark is emptied
            mem_wr_en   = mark_dn || mark_up;
            mem_wr_addr = cur_slot_ff;
         end
         skew_pkg::ST_MOD: begin
            mem_wr_en   = mod_done;
            mem_wr_addr = mod_slot;
            mem_wr_data = hold_down_ff ? skew_pkg::MARK_DOWN : skew_pkg::MARK_UP;
         end
         skew_pkg::ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      now_ms_in      = now_ms_ff;
      cur_slot_in    = cur_slot_ff;
      walk_in        = walk_ff;
      down_start_in  = down_start_ff;
      armed_in       = armed_ff;
      key_in         = key_ff;
      dtr_in         = dtr_ff;
      rts_in         = rts_ff;
      hold_down_in   = hold_down_ff;
      hold_target_in = hold_target_ff;
      hold_origin_in = hold_origin_ff;
      rsp_valid_in   = 1'b0;
      rsp_ack_in     = rsp_ack_ff;
      rsp_origin_in  = rsp_origin_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_sent_in    = rsp_sent_ff;
      rsp_dtr_in     = rsp_dtr_ff;
      rsp_rts_in     = rsp_rts_ff;
      rsp_key_in     = rsp_key_ff;
      case (state_ff)
         skew_pkg::ST_INIT: begin
            walk_in = (walk_ff == LAST_SLOT) ? '0 : (walk_ff + SLOT_W'(1));
         end
         skew_pkg::ST_IDLE: begin
            if (accept) begin
               hold_down_in   = (req_cmd == skew_pkg::CMD_DOWN);
               hold_target_in = req_target_time;
               hold_origin_in = req_origin_time;
               walk_in        = '0;
               case (req_cmd)
                  skew_pkg::CMD_TICK: begin
                     now_ms_in   = now_ms_ff + 32'd1;
                     cur_slot_in = next_slot;
                  end
                  skew_pkg::CMD_DOWN: begin
                     down_start_in = now_ms_ff;
                     armed_in      = 1'b1;
                  end
                  skew_pkg::CMD_UP: begin
                     armed_in = 1'b0;
                  end
                  skew_pkg::CMD_CLEAR: begin
                     armed_in = armed_ff;
                  end
                  default: begin
                     // ping, check and unknown answer at once
                     rsp_valid_in  = 1'b1;
                     rsp_ack_in    = (req_cmd == skew_pkg::CMD_PING)  ? skew_pkg::ACK_PING :
                                     (req_cmd == skew_pkg::CMD_CHECK) ? skew_pkg::ACK_CHECK :
                                                                        skew_pkg::ACK_NONE;
                     rsp_origin_in = req_origin_time;
                     rsp_target_in = req_target_time;
                     rsp_sent_in   = now_ms_ff;
                     rsp_dtr_in    = dtr_ff;
                     rsp_rts_in    = rts_ff;
                     rsp_key_in    = key_ff;
                  end
               endcase
            end
         end
         skew_pkg::ST_TICK: begin
            if (wd_fire) armed_in = 1'b0;
            key_in        = mark_dn ? 1'b1 : (key_event ? 1'b0 : key_ff);
            dtr_in        = dtr_tick;
            rts_in        = rts_tick;
            rsp_valid_in  = 1'b1;
            rsp_ack_in    = skew_pkg::ACK_NONE;
            rsp_origin_in = '0;
            rsp_target_in = '0;
            rsp_sent_in   = now_ms_ff;
            rsp_dtr_in    = dtr_tick;
            rsp_rts_in    = rts_tick;
            rsp_key_in    = mark_dn ? 1'b1 : (key_event ? 1'b0 : key_ff);
         end
         skew_pkg::ST_MOD: begin
            if (mod_done) begin
               rsp_valid_in  = 1'b1;
               rsp_ack_in    = hold_down_ff ? skew_pkg::ACK_DOWN : skew_pkg::ACK_UP;
               rsp_origin_in = hold_origin_ff;
               rsp_target_in = hold_target_ff;
               rsp_sent_in   = now_ms_ff;
               rsp_dtr_in    = dtr_ff;
               rsp_rts_in    = rts_ff;
               rsp_key_in    = key_ff;
            end
         end
         skew_pkg::ST_CLEAR: begin
            walk_in = walk_ff + SLOT_W'(1);
            if (walk_ff == LAST_SLOT) begin
               walk_in       = '0;
               key_in        = 1'b0;
               dtr_in        = dtr_clr;
               rts_in        = rts_clr;
               rsp_valid_in  = 1'b1;
               rsp_ack_in    = skew_pkg::ACK_CLEARED;
               rsp_origin_in = hold_origin_ff;
               rsp_target_in = hold_target_ff;
               rsp_sent_in   = now_ms_ff;
               rsp_dtr_in    = dtr_clr;
               rsp_rts_in    = rts_clr;
               rsp_key_in    = 1'b0;
            end
         end
         default: begin
            walk_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= skew_pkg::ST_INIT;
         now_ms_ff     <= '0;
         cur_slot_ff   <= '0;
         walk_ff       <= '0;
         down_start_ff <= '0;
         armed_ff      <= 1'b0;
         key_ff        <= 1'b0;
         dtr_ff        <= 1'b1;
         rts_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ms_ff     <= now_ms_in;
         cur_slot_ff   <= cur_slot_in;
         walk_ff       <= walk_in;
         down_start_ff <= down_start_in;
         armed_ff      <= armed_in;
         key_ff        <= key_in;
         dtr_ff        <= dtr_in;
         rts_ff        <= rts_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_down_ff   <= hold_down_in;
      hold_target_ff <= hold_target_in;
      hold_origin_ff <= hold_origin_in;
      rsp_ack_ff     <= rsp_ack_in;
      rsp_origin_ff  <= rsp_origin_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_sent_ff    <= rsp_sent_in;
      rsp_dtr_ff     <= rsp_dtr_in;
      rsp_rts_ff     <= rsp_rts_in;
      rsp_key_ff     <= rsp_key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ack_code    = rsp_ack_ff;
   assign rsp_origin_echo = rsp_origin_ff;
   assign rsp_target_echo = rsp_target_ff;
   assign rsp_sent_time   = rsp_sent_ff;
   assign rsp_dtr_level   = rsp_dtr_ff;
   assign rsp_rts_level   = rsp_rts_ff;
   assign rsp_key_is_down = rsp_key_ff;

   // an accepted request either answers next cycle or keeps the block busy
   `SKEW_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid_ff,
      "accepted request neither answered nor busy")
   // a down acknowledge always leaves the watchdog armed
   `SKEW_ASSERT_NOW(a_down_armed, clock, reset,
      rsp_valid_ff && (rsp_ack_ff == skew_pkg::ACK_DOWN), armed_ff,
      "down acknowledge with watchdog disarmed")
   // the slot remainder only completes while a schedule is pending
   `SKEW_ASSERT_NOW(a_mod_done_state, clock, reset, mod_done,
      state_ff == skew_pkg::ST_MOD, "slot remainder done outside schedule")

endmodule

/* hw/rtl/skew_wheel_ram.sv */
`timescale 1ns / 1ps

module skew_wheel_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [1:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [1:0]        rd_data
);

   logic [1:0] mem [DEPTH];
   logic [1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/skew_slot_mod.sv */
`timescale 1ns / 1ps

// remainder of a time by the slot count through a reciprocal estimate
// stage one: quotient estimate, at most one short of the true quotient
// stage two: estimate times slot count, low bits only
// stage three: difference and one conditional subtract
module skew_slot_mod #(
   parameter int SLOTS  = 1024,
   parameter int SLOT_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [skew_pkg::TIME_W-1:0] dividend,
   output logic                        done,
   output logic [SLOT_W-1:0]           slot
);

   localparam logic [SLOT_W:0] SLOTS_L = (SLOT_W+1)'(SLOTS);
   localparam logic [skew_pkg::TIME_W-1:0] RECIP =
      skew_pkg::TIME_W'((64'd1 << skew_pkg::TIME_W) / 64'(SLOTS));

   logic                            v1_ff, v1_in;
   logic                            v2_ff, v2_in;
   logic                            v3_ff, v3_in;
   logic                            done_ff, done_in;
   logic [skew_pkg::TIME_W-1:0]     dvd_ff, dvd_in;
   logic [skew_pkg::TIME_W-1:0]     quot_ff, quot_in;
   logic [SLOT_W:0]                 back_ff, back_in;
   logic [SLOT_W-1:0]               slot_ff, slot_in;
   logic [2*skew_pkg::TIME_W-1:0]   prod;
   logic [SLOT_W:0]                 part;
   logic [SLOT_W:0]                 fold;

   // estimate, back product and correction
   always_comb begin
      prod    = 64'(dvd_ff) * 64'(RECIP);
      quot_in = prod[2*skew_pkg::TIME_W-1:skew_pkg::TIME_W];
      back_in = quot_ff[SLOT_W:0] * SLOTS_L;
      part    = dvd_ff[SLOT_W:0] - back_ff;
      fold    = part - SLOTS_L;
      slot_in = (part >= SLOTS_L) ? fold[SLOT_W-1:0] : part[SLOT_W-1:0];
   end

   // stage control
   always_comb begin
      v1_in   = start;
      v2_in   = v1_ff;
      v3_in   = v2_ff;
      done_in = v3_ff;
      dvd_in  = start ? dividend : dvd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
      back_ff <= back_in;
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

/* hw/rtl/skew_csr.sv */
`timescale 1ns / 1ps

module skew_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output skew_pkg::cfg_type   cfg
);

   skew_pkg::cfg_type cfg_ff, cfg_in;
   skew_pkg::reg_type reg_sel;
   logic              wr_hit;

   assign reg_sel = skew_pkg::reg_type'(paddr[3:2]);
   assign wr_hit  = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register writes, masked to width
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (reg_sel)
            skew_pkg::REG_INVERT:  cfg_in.invert_level  = pwdata[0];
            skew_pkg::REG_ENABLE:  cfg_in.output_enable = pwdata[0];
            skew_pkg::REG_LINE:    cfg_in.line_select   = pwdata[0];
            skew_pkg::REG_TIMEOUT: begin
               cfg_in.down_timeout_ms = pwdata[skew_pkg::TIMEOUT_W-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_level    <= 1'b0;
         cfg_ff.output_enable   <= 1'b0;
         cfg_ff.line_select     <= 1'b0;
         cfg_ff.down_timeout_ms <= skew_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         skew_pkg::REG_INVERT:  prdata = {31'b0, cfg_ff.invert_level};
         skew_pkg::REG_ENABLE:  prdata = {31'b0, cfg_ff.output_enable};
         skew_pkg::REG_LINE:    prdata = {31'b0, cfg_ff.line_select};
         skew_pkg::REG_TIMEOUT: prdata = {16'b0, cfg_ff.down_timeout_ms};
         default:               prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
